// ----- src/kabf_pkg.sv -----
//------------------------------------------------------------------------------
// kabf_pkg
// Types, codes, reset constants and the step program of the angle/bias filter.
//------------------------------------------------------------------------------
`default_nettype none
package kabf_pkg;

	localparam int FIELD_BITS = 48;
	localparam int CFG_IDX_BITS = 3;
	localparam int PC_BITS = 6;

	localparam logic [47:0] RST_A00 = 48'd4294967296;
	localparam logic [47:0] RST_A01 = 48'hFFFF_FFBE_76C9;
	localparam logic [47:0] RST_A11 = 48'd4294967296;
	localparam logic [47:0] RST_B = 48'd4294967;
	localparam logic [47:0] RST_C = 48'd4294967296;
	localparam logic [47:0] RST_QA = 48'd429497;
	localparam logic [47:0] RST_QB = 48'd429497;
	localparam logic [47:0] RST_R = 48'd4294967296;
	localparam int COV_RESET = 429497;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_A00 = 3'd0,
		CFG_A01 = 3'd1,
		CFG_A11 = 3'd2,
		CFG_B = 3'd3,
		CFG_C = 3'd4,
		CFG_QA = 3'd5,
		CFG_QB = 3'd6,
		CFG_R = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB,
		OP_DIV,
		OP_END
	} op_t;

	typedef enum logic [4:0] {
		SL_ANG, SL_BIAS, SL_P00, SL_P01, SL_P10, SL_P11,
		SL_A00, SL_A01, SL_A11, SL_B, SL_C, SL_QA, SL_QB, SL_R,
		SL_U, SL_Y, SL_ONE, SL_ZERO,
		SL_T0, SL_T1, SL_T2, SL_T3, SL_T4, SL_T5, SL_T6,
		SL_K0, SL_K1, SL_ERR
	} slot_t;

	typedef struct packed {
		op_t op;
		slot_t dst;
		slot_t sa;
		slot_t sb;
	} instr_t;

	typedef struct packed {
		logic done;
		logic sat;
	} unit_status_t;

	function automatic instr_t mk(op_t op, slot_t dst, slot_t sa, slot_t sb);
		instr_t i;
		i.op = op;
		i.dst = dst;
		i.sa = sa;
		i.sb = sb;
		return i;
	endfunction

	// predict, innovation, gain, correct, covariance update
	function automatic instr_t prog(logic [PC_BITS-1:0] pc);
		instr_t i;
		case (pc)
			6'd0: i = mk(OP_MUL, SL_T0, SL_A00, SL_ANG);
			6'd1: i = mk(OP_MUL, SL_T1, SL_A01, SL_BIAS);
			6'd2: i = mk(OP_ADD, SL_T0, SL_T0, SL_T1);
			6'd3: i = mk(OP_MUL, SL_T1, SL_B, SL_U);
			6'd4: i = mk(OP_ADD, SL_ANG, SL_T0, SL_T1);
			6'd5: i = mk(OP_MUL, SL_BIAS, SL_A11, SL_BIAS);
			6'd6: i = mk(OP_MUL, SL_T0, SL_A00, SL_P00);
			6'd7: i = mk(OP_MUL, SL_T1, SL_A01, SL_P10);
			6'd8: i = mk(OP_ADD, SL_T0, SL_T0, SL_T1);
			6'd9: i = mk(OP_MUL, SL_T1, SL_A00, SL_P01);
			6'd10: i = mk(OP_MUL, SL_T2, SL_A01, SL_P11);
			6'd11: i = mk(OP_ADD, SL_T1, SL_T1, SL_T2);
			6'd12: i = mk(OP_MUL, SL_T2, SL_A11, SL_P10);
			6'd13: i = mk(OP_MUL, SL_T3, SL_A11, SL_P11);
			6'd14: i = mk(OP_MUL, SL_T4, SL_T0, SL_A00);
			6'd15: i = mk(OP_MUL, SL_T5, SL_T1, SL_A01);
			6'd16: i = mk(OP_ADD, SL_T4, SL_T4, SL_T5);
			6'd17: i = mk(OP_MUL, SL_P01, SL_T1, SL_A11);
			6'd18: i = mk(OP_MUL, SL_T5, SL_T2, SL_A00);
			6'd19: i = mk(OP_MUL, SL_T6, SL_T3, SL_A01);
			6'd20: i = mk(OP_ADD, SL_P10, SL_T5, SL_T6);
			6'd21: i = mk(OP_MUL, SL_T5, SL_T3, SL_A11);
			6'd22: i = mk(OP_ADD, SL_P00, SL_T4, SL_QA);
			6'd23: i = mk(OP_ADD, SL_P11, SL_T5, SL_QB);
			6'd24: i = mk(OP_MUL, SL_T0, SL_C, SL_ANG);
			6'd25: i = mk(OP_SUB, SL_ERR, SL_Y, SL_T0);
			6'd26: i = mk(OP_MUL, SL_T0, SL_C, SL_P00);
			6'd27: i = mk(OP_MUL, SL_T0, SL_T0, SL_C);
			6'd28: i = mk(OP_ADD, SL_T0, SL_T0, SL_R);
			6'd29: i = mk(OP_MUL, SL_T1, SL_P00, SL_C);
			6'd30: i = mk(OP_DIV, SL_K0, SL_T1, SL_T0);
			6'd31: i = mk(OP_MUL, SL_T1, SL_P10, SL_C);
			6'd32: i = mk(OP_DIV, SL_K1, SL_T1, SL_T0);
			6'd33: i = mk(OP_MUL, SL_T1, SL_K0, SL_ERR);
			6'd34: i = mk(OP_ADD, SL_ANG, SL_ANG, SL_T1);
			6'd35: i = mk(OP_MUL, SL_T1, SL_K1, SL_ERR);
			6'd36: i = mk(OP_ADD, SL_BIAS, SL_BIAS, SL_T1);
			6'd37: i = mk(OP_MUL, SL_T1, SL_K0, SL_C);
			6'd38: i = mk(OP_SUB, SL_T1, SL_ONE, SL_T1);
			6'd39: i = mk(OP_MUL, SL_T2, SL_K1, SL_C);
			6'd40: i = mk(OP_SUB, SL_T2, SL_ZERO, SL_T2);
			6'd41: i = mk(OP_MUL, SL_T3, SL_T2, SL_P00);
			6'd42: i = mk(OP_MUL, SL_T4, SL_ONE, SL_P10);
			6'd43: i = mk(OP_ADD, SL_P10, SL_T3, SL_T4);
			6'd44: i = mk(OP_MUL, SL_T4, SL_T2, SL_P01);
			6'd45: i = mk(OP_MUL, SL_T5, SL_ONE, SL_P11);
			6'd46: i = mk(OP_ADD, SL_P11, SL_T4, SL_T5);
			6'd47: i = mk(OP_MUL, SL_P00, SL_T1, SL_P00);
			6'd48: i = mk(OP_MUL, SL_P01, SL_T1, SL_P01);
			default: i = mk(OP_END, SL_T0, SL_T0, SL_T0);
		endcase
		return i;
	endfunction

endpackage
`default_nettype wire

// ----- src/kabf_in_if.sv -----
//------------------------------------------------------------------------------
// kabf_in_if
// Sample channel: function code, gyro rate and measured angle.
//------------------------------------------------------------------------------
`default_nettype none
interface kabf_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [47:0] rate_in;
	logic [47:0] angle_meas;

	modport source (output valid, output func, output rate_in, output angle_meas, input ready);
	modport sink (input valid, input func, input rate_in, input angle_meas, output ready);
endinterface
`default_nettype wire

// ----- src/kabf_out_if.sv -----
//------------------------------------------------------------------------------
// kabf_out_if
// Result channel: corrected angle, bias and saturation flag.
//------------------------------------------------------------------------------
`default_nettype none
interface kabf_out_if;
	logic valid;
	logic ready;
	logic [47:0] angle_est;
	logic [47:0] bias_est;
	logic sat_flag;

	modport source (output valid, output angle_est, output bias_est, output sat_flag, input ready);
	modport sink (input valid, input angle_est, input bias_est, input sat_flag, output ready);
endinterface
`default_nettype wire

// ----- src/kabf_cfg_if.sv -----
//------------------------------------------------------------------------------
// kabf_cfg_if
// Register write channel: register index and write data.
//------------------------------------------------------------------------------
`default_nettype none
interface kabf_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [47:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/kabf_mul.sv -----
//------------------------------------------------------------------------------
// kabf_mul
// Fixed-point multiplier, four multiplier bits a cycle, round and saturate.
//------------------------------------------------------------------------------
`default_nettype none
module kabf_mul #(
	parameter int W = 48,
	parameter int F = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [W-1:0] a,
	input wire logic [W-1:0] b,
	output logic [W-1:0] res,
	output kabf_pkg::unit_status_t status
);
	localparam int MW = ((W + 3) / 4) * 4;
	localparam int STEPS = MW / 4;
	localparam int CW = $clog2(STEPS);
	localparam int PW = 2 * MW + 1;

	logic run_q, fin_q, done_q, sat_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] am_q;
	logic [2*MW-1:0] acc_q;
	logic [W-1:0] res_q;
	logic [W-1:0] mag_a, mag_b;
	logic [MW+3:0] sum;
	logic [PW-1:0] rnd, m, lim, sel;
	logic sat;

	assign mag_a = a[W-1] ? (~a + W'(1)) : a;
	assign mag_b = b[W-1] ? (~b + W'(1)) : b;
	assign sum = (MW+4)'(acc_q[2*MW-1:MW]) + (MW+4)'(am_q * acc_q[3:0]);

	always_comb begin
		rnd = {1'b0, acc_q} + (PW'(1) << (F - 1));
		m = rnd >> F;
		lim = (PW'(1) << (W - 1)) - (neg_q ? PW'(0) : PW'(1));
		sat = m > lim;
		sel = sat ? lim : m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[W-1] ^ b[W-1];
			am_q <= MW'(mag_a);
			acc_q <= {MW'(0), MW'(mag_b)};
		end else if (run_q) begin
			acc_q <= {sum, acc_q[MW-1:4]};
		end
		if (fin_q) begin
			sat_q <= sat;
			res_q <= neg_q ? (~sel[W-1:0] + W'(1)) : sel[W-1:0];
		end
	end

	assign res = res_q;
	assign status.done = done_q;
	assign status.sat = sat_q;
endmodule
`default_nettype wire

// ----- src/kabf_div.sv -----
//------------------------------------------------------------------------------
// kabf_div
// Fixed-point restoring divider, one quotient bit a cycle, round and saturate.
//------------------------------------------------------------------------------
`default_nettype none
module kabf_div #(
	parameter int W = 48,
	parameter int F = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [W-1:0] num,
	input wire logic [W-1:0] den,
	output logic [W-1:0] res,
	output kabf_pkg::unit_status_t status
);
	localparam int NB = W + F;
	localparam int CW = $clog2(NB);

	logic run_q, fin_q, done_q, sat_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [NB-1:0] dq_q;
	logic [W-1:0] r_q, d_q, res_q;
	logic [W-1:0] mag_n, mag_d;
	logic [W:0] rs;
	logic ge, rnd_up;
	logic [NB:0] q, lim, sel;
	logic sat;

	assign mag_n = num[W-1] ? (~num + W'(1)) : num;
	assign mag_d = den[W-1] ? (~den + W'(1)) : den;
	assign rs = {r_q, dq_q[NB-1]};
	assign ge = rs >= {1'b0, d_q};

	always_comb begin
		rnd_up = {r_q, 1'b0} >= {1'b0, d_q};
		q = {1'b0, dq_q} + (NB+1)'(rnd_up);
		lim = ((NB+1)'(1) << (W - 1)) - (neg_q ? (NB+1)'(0) : (NB+1)'(1));
		sat = q > lim;
		sel = sat ? lim : q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NB - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[W-1] ^ den[W-1];
			dq_q <= {mag_n, F'(0)};
			r_q <= '0;
			d_q <= mag_d;
		end else if (run_q) begin
			r_q <= ge ? W'(rs - {1'b0, d_q}) : rs[W-1:0];
			dq_q <= {dq_q[NB-2:0], ge};
		end
		if (fin_q) begin
			sat_q <= sat;
			res_q <= neg_q ? (~sel[W-1:0] + W'(1)) : sel[W-1:0];
		end
	end

	assign res = res_q;
	assign status.done = done_q;
	assign status.sat = sat_q;
endmodule
`default_nettype wire

// ----- src/kalman_angle_bias_filter.sv -----
//------------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state angle/bias Kalman filter run as a program on a shared mul and div.
//------------------------------------------------------------------------------
// Init request: state set on acceptance, result loaded from the done state.
// Predict/correct request: result after the program has run its steps on the
// shared 4-bit-a-cycle multiplier and the 1-bit-a-cycle divider. One request
// at a time; next accepted once the result is loaded and the block is idle with
// no register write pending; loading waits while the previous one is untaken.
// Reset: asynchronous, registers to their defaults, state zero, P = diag(q).
`default_nettype none
module kalman_angle_bias_filter #(
	parameter int FRAC_BITS = 32,
	parameter int WORD_BITS = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	kabf_cfg_if.sink cfg,
	kabf_in_if.sink sample,
	kabf_out_if.source result
);
	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam logic signed [64:0] WMAX_L = (65'sd1 <<< (W - 1)) - 65'sd1;
	localparam logic signed [64:0] WMIN_L = -WMAX_L - 65'sd1;
	localparam logic ONE_CLIP = (F >= W - 1);
	localparam logic [64:0] ONE_RAW = 65'd1 << F;
	localparam logic [W-1:0] ONE_W = ONE_CLIP ? WMAX_L[W-1:0] : ONE_RAW[W-1:0];

	function automatic logic [W:0] clampw(logic signed [64:0] v);
		if (v > WMAX_L) return {1'b1, WMAX_L[W-1:0]};
		if (v < WMIN_L) return {1'b1, WMIN_L[W-1:0]};
		return {1'b0, v[W-1:0]};
	endfunction

	function automatic logic [47:0] sx(logic [W-1:0] v);
		logic [64:0] t;
		t = {{(65 - W){v[W-1]}}, v};
		return t[47:0];
	endfunction

	function automatic logic [64:0] s48(logic [47:0] v);
		return {{17{v[47]}}, v};
	endfunction

	function automatic logic [64:0] u47(logic [47:0] v);
		return {18'd0, v[46:0]};
	endfunction

	kabf_pkg::state_t state_q, state_d;
	logic [kabf_pkg::PC_BITS-1:0] pc_q;
	logic [47:0] cfg_q [8];
	logic [W:0] cl [8];
	logic [W:0] cl_u, cl_y;
	logic [W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic [W-1:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, k0_q, k1_q, err_q, u_q, y_q;
	logic flag_q;
	logic out_valid_q, out_sat_q;
	logic [47:0] out_ang_q, out_bias_q;
	kabf_pkg::instr_t ins;
	logic [W-1:0] opa, opb, mul_res, div_res, wr_val;
	kabf_pkg::unit_status_t mul_st, div_st;
	logic [W:0] alu;
	logic alu_ovf;
	logic accept, mul_start, div_start, wr_en, wr_flag, pc_inc, out_load;

	assign accept = sample.valid && sample.ready;
	assign cfg.ready = 1'b1;
	assign ins = kabf_pkg::prog(pc_q);

	always_comb begin
		cl[0] = clampw(s48(cfg_q[0]));
		cl[1] = clampw(s48(cfg_q[1]));
		cl[2] = clampw(s48(cfg_q[2]));
		cl[3] = clampw(s48(cfg_q[3]));
		cl[4] = clampw(s48(cfg_q[4]));
		cl[5] = clampw(u47(cfg_q[5]));
		cl[6] = clampw(u47(cfg_q[6]));
		cl[7] = clampw(u47(cfg_q[7]));
		cl_u = clampw(s48(sample.rate_in));
		cl_y = clampw(s48(sample.angle_meas));
	end

	function automatic logic [W-1:0] rd(kabf_pkg::slot_t s, logic [W-1:0] st [6],
			logic [W-1:0] tmp [12], logic [W:0] c [8]);
		case (s)
			kabf_pkg::SL_ANG: return st[0];
			kabf_pkg::SL_BIAS: return st[1];
			kabf_pkg::SL_P00: return st[2];
			kabf_pkg::SL_P01: return st[3];
			kabf_pkg::SL_P10: return st[4];
			kabf_pkg::SL_P11: return st[5];
			kabf_pkg::SL_A00: return c[kabf_pkg::CFG_A00][W-1:0];
			kabf_pkg::SL_A01: return c[kabf_pkg::CFG_A01][W-1:0];
			kabf_pkg::SL_A11: return c[kabf_pkg::CFG_A11][W-1:0];
			kabf_pkg::SL_B: return c[kabf_pkg::CFG_B][W-1:0];
			kabf_pkg::SL_C: return c[kabf_pkg::CFG_C][W-1:0];
			kabf_pkg::SL_QA: return c[kabf_pkg::CFG_QA][W-1:0];
			kabf_pkg::SL_QB: return c[kabf_pkg::CFG_QB][W-1:0];
			kabf_pkg::SL_R: return c[kabf_pkg::CFG_R][W-1:0];
			kabf_pkg::SL_U: return tmp[10];
			kabf_pkg::SL_Y: return tmp[11];
			kabf_pkg::SL_ONE: return ONE_W;
			kabf_pkg::SL_T0: return tmp[0];
			kabf_pkg::SL_T1: return tmp[1];
			kabf_pkg::SL_T2: return tmp[2];
			kabf_pkg::SL_T3: return tmp[3];
			kabf_pkg::SL_T4: return tmp[4];
			kabf_pkg::SL_T5: return tmp[5];
			kabf_pkg::SL_T6: return tmp[6];
			kabf_pkg::SL_K0: return tmp[7];
			kabf_pkg::SL_K1: return tmp[8];
			kabf_pkg::SL_ERR: return tmp[9];
			default: return '0;
		endcase
	endfunction

	logic [W-1:0] st_v [6];
	logic [W-1:0] tmp_v [12];

	always_comb begin
		st_v[0] = ang_q;
		st_v[1] = bias_q;
		st_v[2] = p00_q;
		st_v[3] = p01_q;
		st_v[4] = p10_q;
		st_v[5] = p11_q;
		tmp_v[0] = t0_q;
		tmp_v[1] = t1_q;
		tmp_v[2] = t2_q;
		tmp_v[3] = t3_q;
		tmp_v[4] = t4_q;
		tmp_v[5] = t5_q;
		tmp_v[6] = t6_q;
		tmp_v[7] = k0_q;
		tmp_v[8] = k1_q;
		tmp_v[9] = err_q;
		tmp_v[10] = u_q;
		tmp_v[11] = y_q;
		opa = rd(ins.sa, st_v, tmp_v, cl);
		opb = rd(ins.sb, st_v, tmp_v, cl);
	end

	always_comb begin
		if (ins.op == kabf_pkg::OP_SUB) alu = {opa[W-1], opa} - {opb[W-1], opb};
		else alu = {opa[W-1], opa} + {opb[W-1], opb};
		alu_ovf = alu[W] != alu[W-1];
	end

	kabf_mul #(.W(W), .F(F)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(opa), .b(opb), .res(mul_res), .status(mul_st)
	);

	kabf_div #(.W(W), .F(F)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(opa), .den(opb), .res(div_res), .status(div_st)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kabf_pkg::ST_IDLE: begin
				if (accept) state_d = sample.func ? kabf_pkg::ST_DONE : kabf_pkg::ST_FETCH;
			end
			kabf_pkg::ST_FETCH: begin
				if (ins.op == kabf_pkg::OP_END) state_d = kabf_pkg::ST_DONE;
				else if (ins.op == kabf_pkg::OP_MUL) state_d = kabf_pkg::ST_WAIT;
				else if (ins.op == kabf_pkg::OP_DIV && opb != '0) state_d = kabf_pkg::ST_WAIT;
			end
			kabf_pkg::ST_WAIT: begin
				if (mul_st.done || div_st.done) state_d = kabf_pkg::ST_FETCH;
			end
			kabf_pkg::ST_DONE: begin
				if (!out_valid_q || result.ready) state_d = kabf_pkg::ST_IDLE;
			end
			default: state_d = kabf_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		sample.ready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		wr_en = 1'b0;
		wr_flag = 1'b0;
		wr_val = alu[W-1:0];
		pc_inc = 1'b0;
		out_load = 1'b0;
		case (state_q)
			// a register write takes the edge on its own
			kabf_pkg::ST_IDLE: sample.ready = !cfg.valid;
			kabf_pkg::ST_FETCH: begin
				case (ins.op)
					kabf_pkg::OP_ADD, kabf_pkg::OP_SUB: begin
						wr_en = 1'b1;
						pc_inc = 1'b1;
						wr_flag = alu_ovf;
						if (alu_ovf) wr_val = alu[W] ? WMIN_L[W-1:0] : WMAX_L[W-1:0];
					end
					kabf_pkg::OP_MUL: mul_start = 1'b1;
					kabf_pkg::OP_DIV: begin
						if (opb == '0) begin
							wr_en = 1'b1;
							wr_flag = 1'b1;
							wr_val = '0;
							pc_inc = 1'b1;
						end else begin
							div_start = 1'b1;
						end
					end
					default: ;
				endcase
			end
			kabf_pkg::ST_WAIT: begin
				if (mul_st.done) begin
					wr_en = 1'b1;
					wr_flag = mul_st.sat;
					wr_val = mul_res;
					pc_inc = 1'b1;
				end else if (div_st.done) begin
					wr_en = 1'b1;
					wr_flag = div_st.sat;
					wr_val = div_res;
					pc_inc = 1'b1;
				end
			end
			kabf_pkg::ST_DONE: out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kabf_pkg::ST_IDLE;
			pc_q <= '0;
			flag_q <= 1'b0;
			out_valid_q <= 1'b0;
			cfg_q[kabf_pkg::CFG_A00] <= kabf_pkg::RST_A00;
			cfg_q[kabf_pkg::CFG_A01] <= kabf_pkg::RST_A01;
			cfg_q[kabf_pkg::CFG_A11] <= kabf_pkg::RST_A11;
			cfg_q[kabf_pkg::CFG_B] <= kabf_pkg::RST_B;
			cfg_q[kabf_pkg::CFG_C] <= kabf_pkg::RST_C;
			cfg_q[kabf_pkg::CFG_QA] <= kabf_pkg::RST_QA;
			cfg_q[kabf_pkg::CFG_QB] <= kabf_pkg::RST_QB;
			cfg_q[kabf_pkg::CFG_R] <= kabf_pkg::RST_R;
			ang_q <= '0;
			bias_q <= '0;
			p00_q <= W'(kabf_pkg::COV_RESET);
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= W'(kabf_pkg::COV_RESET);
		end else begin
			state_q <= state_d;
			if (pc_inc) pc_q <= pc_q + kabf_pkg::PC_BITS'(1);
			if (wr_flag) flag_q <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			if (cfg.valid) begin
				if (cfg.index < 3'(kabf_pkg::CFG_QA)) cfg_q[cfg.index] <= cfg.data;
				else cfg_q[cfg.index] <= {1'b0, cfg.data[46:0]};
			end
			if (accept) begin
				pc_q <= '0;
				// registers clamp to the word range in place
				for (int i = 0; i < 8; i++) cfg_q[i] <= sx(cl[i][W-1:0]);
				flag_q <= cl[0][W] | cl[1][W] | cl[2][W] | cl[3][W] | cl[4][W] |
					cl[5][W] | cl[6][W] | cl[7][W] | cl_u[W] | cl_y[W] |
					(ONE_CLIP & !sample.func);
				if (sample.func) begin
					ang_q <= cl_y[W-1:0];
					bias_q <= '0;
					p00_q <= cl[kabf_pkg::CFG_QA][W-1:0];
					p01_q <= '0;
					p10_q <= '0;
					p11_q <= cl[kabf_pkg::CFG_QB][W-1:0];
				end
			end
			if (wr_en) begin
				case (ins.dst)
					kabf_pkg::SL_ANG: ang_q <= wr_val;
					kabf_pkg::SL_BIAS: bias_q <= wr_val;
					kabf_pkg::SL_P00: p00_q <= wr_val;
					kabf_pkg::SL_P01: p01_q <= wr_val;
					kabf_pkg::SL_P10: p10_q <= wr_val;
					kabf_pkg::SL_P11: p11_q <= wr_val;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			u_q <= cl_u[W-1:0];
			y_q <= cl_y[W-1:0];
		end
		if (wr_en) begin
			case (ins.dst)
				kabf_pkg::SL_T0: t0_q <= wr_val;
				kabf_pkg::SL_T1: t1_q <= wr_val;
				kabf_pkg::SL_T2: t2_q <= wr_val;
				kabf_pkg::SL_T3: t3_q <= wr_val;
				kabf_pkg::SL_T4: t4_q <= wr_val;
				kabf_pkg::SL_T5: t5_q <= wr_val;
				kabf_pkg::SL_T6: t6_q <= wr_val;
				kabf_pkg::SL_K0: k0_q <= wr_val;
				kabf_pkg::SL_K1: k1_q <= wr_val;
				kabf_pkg::SL_ERR: err_q <= wr_val;
				default: ;
			endcase
		end
		if (out_load) begin
			out_ang_q <= sx(ang_q);
			out_bias_q <= sx(bias_q);
			out_sat_q <= flag_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.angle_est = out_ang_q;
	assign result.bias_est = out_bias_q;
	assign result.sat_flag = out_sat_q;
endmodule
`default_nettype wire

// ----- src/kabf_checker.sv -----
//------------------------------------------------------------------------------
// kabf_checker
// Port-level checks of the filter's request handshakes, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none
module kabf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic cfg_valid,
	input wire logic cfg_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped before taken");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while a request is in progress");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in progress");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");
endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample.valid),
	.in_ready(sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// Bench for the angle/bias Kalman filter. A queue of register writes, samples
// and drain points feeds a clocked driver; every accepted sample runs through
// a bit-exact fixed-point model of the filter and the expected estimates are
// compared with each returned result. Both channels idle at random.
//------------------------------------------------------------------------------
module tb_top;

	localparam longint WMAX = 64'sd140737488355327;
	localparam longint WMIN = -WMAX - 1;
	localparam logic signed [47:0] ONE_Q = 48'sd4294967296;

	typedef logic signed [47:0] mat2_t [4];

	typedef struct {
		bit drain;
		bit is_cfg;
		kabf_pkg::cfg_idx_t idx;
		logic [47:0] data;
		logic func;
		logic [47:0] rate;
		logic [47:0] meas;
	} job_t;

	typedef struct {
		logic [47:0] angle;
		logic [47:0] bias;
		logic sat;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kabf_cfg_if cfg_if ();
	kabf_in_if sample_if ();
	kabf_out_if result_if ();

	kalman_angle_bias_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if.sink),
		.sample(sample_if.sink),
		.result(result_if.source)
	);

	job_t jobs[$];
	estimate_t pending_est[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int settle = 0;

	// filter model state
	logic signed [47:0] coef [8];
	logic signed [47:0] ang_s, bias_s;
	mat2_t cov;
	bit sat_seen;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [47:0] clip(input longint v);
		if (v > WMAX) begin
			sat_seen = 1'b1;
			return WMAX[47:0];
		end
		if (v < WMIN) begin
			sat_seen = 1'b1;
			return WMIN[47:0];
		end
		return v[47:0];
	endfunction

	function automatic logic signed [47:0] qadd(input logic signed [47:0] a, b);
		return clip(longint'(a) + longint'(b));
	endfunction

	function automatic logic signed [47:0] qsub(input logic signed [47:0] a, b);
		return clip(longint'(a) - longint'(b));
	endfunction

	function automatic logic signed [47:0] from_mag(input logic [127:0] mg, input bit neg);
		logic [127:0] lim;
		lim = 128'h7FFF_FFFF_FFFF + (neg ? 128'd1 : 128'd0);
		if (mg > lim) begin
			sat_seen = 1'b1;
			mg = lim;
		end
		return neg ? -mg[47:0] : mg[47:0];
	endfunction

	function automatic logic [47:0] abs48(input logic signed [47:0] v);
		return v[47] ? ~v + 48'd1 : v;
	endfunction

	function automatic logic signed [47:0] qmul(input logic signed [47:0] a, b);
		logic [127:0] m;
		m = {80'd0, abs48(a)} * {80'd0, abs48(b)};
		m = (m + 128'h8000_0000) >> 32;
		return from_mag(m, a[47] ^ b[47]);
	endfunction

	function automatic logic signed [47:0] qdiv(input logic signed [47:0] n, d);
		logic [127:0] nn, dd, q, r;
		nn = {80'd0, abs48(n)} << 32;
		dd = {80'd0, abs48(d)};
		q = nn / dd;
		r = nn % dd;
		if (r >= dd - r)
			q = q + 128'd1;
		return from_mag(q, n[47] ^ d[47]);
	endfunction

	function automatic mat2_t mat_prod(input mat2_t x, input mat2_t y);
		mat2_t t;
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				t[i*2+j] = qadd(qmul(x[i*2], y[j]), qmul(x[i*2+1], y[2+j]));
		return t;
	endfunction

	function automatic void reset_model();
		coef[kabf_pkg::CFG_A00] = kabf_pkg::RST_A00;
		coef[kabf_pkg::CFG_A01] = kabf_pkg::RST_A01;
		coef[kabf_pkg::CFG_A11] = kabf_pkg::RST_A11;
		coef[kabf_pkg::CFG_B] = kabf_pkg::RST_B;
		coef[kabf_pkg::CFG_C] = kabf_pkg::RST_C;
		coef[kabf_pkg::CFG_QA] = kabf_pkg::RST_QA;
		coef[kabf_pkg::CFG_QB] = kabf_pkg::RST_QB;
		coef[kabf_pkg::CFG_R] = kabf_pkg::RST_R;
		ang_s = '0;
		bias_s = '0;
		cov = '{48'sd429497, 48'sd0, 48'sd0, 48'sd429497};
	endfunction

	function automatic void write_coef(input kabf_pkg::cfg_idx_t idx, input logic [47:0] d);
		if (idx inside {kabf_pkg::CFG_QA, kabf_pkg::CFG_QB, kabf_pkg::CFG_R})
			coef[idx] = {1'b0, d[46:0]};
		else
			coef[idx] = d;
	endfunction

	function automatic estimate_t filter_step(input logic func, input logic signed [47:0] u, y);
		mat2_t a, at, p, m;
		logic signed [47:0] x0, x1, c, err, den, pct;
		logic signed [47:0] k [2];
		estimate_t e;
		sat_seen = 1'b0;
		if (func) begin
			ang_s = y;
			bias_s = '0;
			cov = '{coef[kabf_pkg::CFG_QA], 48'sd0, 48'sd0, coef[kabf_pkg::CFG_QB]};
		end else begin
			c = coef[kabf_pkg::CFG_C];
			a = '{coef[kabf_pkg::CFG_A00], coef[kabf_pkg::CFG_A01], 48'sd0,
				coef[kabf_pkg::CFG_A11]};
			at = '{a[0], a[2], a[1], a[3]};
			x0 = qadd(qadd(qmul(a[0], ang_s), qmul(a[1], bias_s)),
				qmul(coef[kabf_pkg::CFG_B], u));
			x1 = qadd(qadd(qmul(a[2], ang_s), qmul(a[3], bias_s)), 48'sd0);
			p = mat_prod(mat_prod(a, cov), at);
			p[0] = qadd(p[0], coef[kabf_pkg::CFG_QA]);
			p[3] = qadd(p[3], coef[kabf_pkg::CFG_QB]);
			err = qsub(y, qadd(qmul(c, x0), 48'sd0));
			den = qadd(qadd(qmul(qadd(qmul(c, p[0]), 48'sd0), c), 48'sd0),
				coef[kabf_pkg::CFG_R]);
			for (int i = 0; i < 2; i++) begin
				pct = qadd(qmul(p[i*2], c), 48'sd0);
				if (den == 0) begin
					sat_seen = 1'b1;
					k[i] = '0;
				end else begin
					k[i] = qdiv(pct, den);
				end
			end
			x0 = qadd(x0, qmul(k[0], err));
			x1 = qadd(x1, qmul(k[1], err));
			for (int i = 0; i < 4; i++)
				m[i] = qsub((i == 0 || i == 3) ? ONE_Q : 48'sd0,
					qmul(k[i>>1], (i & 1) ? 48'sd0 : c));
			cov = mat_prod(m, p);
			ang_s = x0;
			bias_s = x1;
		end
		e.angle = ang_s;
		e.bias = bias_s;
		e.sat = sat_seen;
		return e;
	endfunction

	function automatic logic [47:0] pick_word();
		longint t;
		t = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 48'(t >>> $urandom_range(22, 50));
			5, 6, 7: return t[47:0];
			default: begin
				case ($urandom_range(0, 4))
					0: return WMAX[47:0];
					1: return WMIN[47:0];
					2: return 48'd0;
					3: return ONE_Q;
					default: return -ONE_Q;
				endcase
			end
		endcase
	endfunction

	task automatic add_sample(input logic func, input logic [47:0] u, y);
		job_t j;
		j = '{drain: 1'b0, is_cfg: 1'b0, idx: kabf_pkg::CFG_A00, data: '0, func: func,
			rate: u, meas: y};
		jobs.push_back(j);
	endtask

	task automatic add_write(input kabf_pkg::cfg_idx_t idx, input logic [47:0] d);
		job_t j;
		j = '{drain: 1'b0, is_cfg: 1'b1, idx: idx, data: d, func: 1'b0, rate: '0, meas: '0};
		jobs.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j = '{drain: 1'b1, is_cfg: 1'b0, idx: kabf_pkg::CFG_A00, data: '0, func: 1'b0,
			rate: '0, meas: '0};
		jobs.push_back(j);
	endtask

	task automatic add_random(input int n);
		logic func;
		for (int i = 0; i < n; i++) begin
			func = ($urandom_range(0, 9) == 0);
			add_sample(func, pick_word(), pick_word());
		end
	endtask

	task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
		errors++;
		$display("mismatch result %0d %s: got %h want %h", received, what, got, want);
	endtask

	// sample and register driver
	job_t head;
	bit s_hold, c_hold, quiet_in;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
			sample_if.func <= 1'b0;
			sample_if.rate_in <= '0;
			sample_if.angle_meas <= '0;
			cfg_if.valid <= 1'b0;
			cfg_if.index <= kabf_pkg::CFG_A00;
			cfg_if.data <= '0;
		end else begin
			if (sample_if.valid && sample_if.ready) begin
				pending_est.push_back(filter_step(sample_if.func, sample_if.rate_in,
					sample_if.angle_meas));
				sent++;
			end
			if (cfg_if.valid && cfg_if.ready)
				write_coef(kabf_pkg::cfg_idx_t'(cfg_if.index), cfg_if.data);
			s_hold = sample_if.valid && !sample_if.ready;
			c_hold = cfg_if.valid && !cfg_if.ready;
			quiet_in = sent >= 400 && sent < 560;
			if (!s_hold && !c_hold) begin
				sample_if.valid <= 1'b0;
				cfg_if.valid <= 1'b0;
				if (settle > 0) begin
					settle--;
				end else if (jobs.size() > 0) begin
					head = jobs[0];
					if (head.drain) begin
						if (pending_est.size() == 0 && !(sample_if.valid && sample_if.ready)) begin
							void'(jobs.pop_front());
							settle = 12;
						end
					end else if (quiet_in || $urandom_range(0, 99) >= 29) begin
						void'(jobs.pop_front());
						if (head.is_cfg) begin
							cfg_if.valid <= 1'b1;
							cfg_if.index <= head.idx;
							cfg_if.data <= head.data;
						end else begin
							sample_if.valid <= 1'b1;
							sample_if.func <= head.func;
							sample_if.rate_in <= head.rate;
							sample_if.angle_meas <= head.meas;
						end
					end
				end
			end
		end
	end

	// result side: random stalls, one long hold-off, and the checker
	int hold_left = 0;
	bit hold_done = 1'b0;
	estimate_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (pending_est.size() == 0) begin
					errors++;
					$display("unexpected result: angle %h bias %h sat %b",
						result_if.angle_est, result_if.bias_est, result_if.sat_flag);
				end else begin
					want = pending_est.pop_front();
					if (result_if.angle_est !== want.angle)
						report("angle_est", result_if.angle_est, want.angle);
					if (result_if.bias_est !== want.bias)
						report("bias_est", result_if.bias_est, want.bias);
					if (result_if.sat_flag !== want.sat)
						report("sat_flag", 48'(result_if.sat_flag), 48'(want.sat));
				end
				received++;
			end
			if (!hold_done && received == 900) begin
				hold_done = 1'b1;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= (received >= 1200 && received < 1360) ||
					$urandom_range(0, 99) >= 29;
			end
		end
	end

	initial begin
		#100ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		reset_model();
		// extremes and patterns of the sample fields at the reset coefficients
		add_sample(1'b1, '0, WMAX[47:0]);
		add_sample(1'b0, WMAX[47:0], WMIN[47:0]);
		add_sample(1'b0, WMIN[47:0], WMAX[47:0]);
		add_sample(1'b1, WMAX[47:0], WMIN[47:0]);
		add_sample(1'b0, '0, '0);
		add_sample(1'b1, WMIN[47:0], '0);
		for (int i = 0; i < 6; i++)
			add_sample(1'b0, 48'd1 << (i * 7), ONE_Q);
		add_sample(1'b0, -ONE_Q, 48'hAAAA_AAAA_AAAA);
		add_sample(1'b0, 48'h5555_5555_5555, -ONE_Q);
		add_drain();
		// zero denominator: no measurement gain, no measurement noise
		add_write(kabf_pkg::CFG_C, '0);
		add_write(kabf_pkg::CFG_R, '0);
		add_sample(1'b1, '0, ONE_Q);
		add_sample(1'b0, ONE_Q, ONE_Q);
		add_sample(1'b0, WMIN[47:0], '0);
		add_drain();
		for (int i = 0; i < 8; i++)
			add_write(kabf_pkg::cfg_idx_t'(i),
				(i == kabf_pkg::CFG_C || i == kabf_pkg::CFG_R) ? ONE_Q : coef[i]);
		add_random(600);
		add_drain();
		// near-unity model with random small terms
		add_write(kabf_pkg::CFG_A00,
			ONE_Q + 48'(longint'($urandom_range(0, 1 << 24)) - (1 << 23)));
		add_write(kabf_pkg::CFG_A01, -48'($urandom_range(1, 1 << 26)));
		add_write(kabf_pkg::CFG_A11, ONE_Q - 48'($urandom_range(0, 1 << 20)));
		add_write(kabf_pkg::CFG_B, 48'($urandom_range(1, 1 << 26)));
		add_write(kabf_pkg::CFG_C, ONE_Q + 48'($urandom_range(0, 1 << 28)));
		add_write(kabf_pkg::CFG_QA, 48'($urandom));
		add_write(kabf_pkg::CFG_QB, 48'($urandom));
		add_write(kabf_pkg::CFG_R, 48'({$urandom, $urandom}) >> 12);
		add_random(450);
		add_drain();
		// coefficient extremes
		add_write(kabf_pkg::CFG_A00, WMAX[47:0]);
		add_write(kabf_pkg::CFG_A01, WMIN[47:0]);
		add_write(kabf_pkg::CFG_A11, WMIN[47:0]);
		add_write(kabf_pkg::CFG_B, WMAX[47:0]);
		add_write(kabf_pkg::CFG_C, WMIN[47:0]);
		add_write(kabf_pkg::CFG_QA, 48'hFFFF_FFFF_FFFF);
		add_write(kabf_pkg::CFG_QB, 48'h7FFF_FFFF_FFFF);
		add_write(kabf_pkg::CFG_R, 48'h8000_0000_0000);
		add_random(150);
		add_drain();
		for (int i = 0; i < 8; i++)
			add_write(kabf_pkg::cfg_idx_t'(i), 48'({$urandom, $urandom}));
		add_random(150);
		add_drain();
		add_write(kabf_pkg::CFG_A00, kabf_pkg::RST_A00);
		add_write(kabf_pkg::CFG_A01, kabf_pkg::RST_A01);
		add_write(kabf_pkg::CFG_A11, kabf_pkg::RST_A11);
		add_write(kabf_pkg::CFG_B, kabf_pkg::RST_B);
		add_write(kabf_pkg::CFG_C, kabf_pkg::RST_C);
		add_write(kabf_pkg::CFG_QA, kabf_pkg::RST_QA);
		add_write(kabf_pkg::CFG_QB, kabf_pkg::RST_QB);
		add_write(kabf_pkg::CFG_R, kabf_pkg::RST_R);
		add_random(430);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (jobs.size() > 0 || sample_if.valid || cfg_if.valid || pending_est.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_est.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/kabf_pkg.sv
src/kabf_in_if.sv
src/kabf_out_if.sv
src/kabf_cfg_if.sv
src/kabf_mul.sv
src/kabf_div.sv
src/kalman_angle_bias_filter.sv
src/kabf_checker.sv
bench/tb_top.sv
